[rtl/fcrc16_pkg.sv]
package fcrc16_pkg;

   localparam int CRC_W       = 16;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 4;
   localparam int MIN_TOP_IDX = 7;

   localparam logic [CRC_W-1:0] GEN_RESET  = 16'h1021;
   localparam logic [CRC_W-1:0] INIT_RESET = 16'hFFFF;

   typedef enum logic [0:0] {
      CSR_GENERATOR_POLY = 1'b0,
      CSR_INITIAL_VALUE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CRC_W-1:0] generator_poly;
      logic [CRC_W-1:0] initial_value;
   } cfg_type;

endpackage

[rtl/fcrc16_if.sv]
interface fcrc16_req_if
   import fcrc16_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcrc16_rsp_if
   import fcrc16_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink   (input valid, input crc_value, output ready);
endinterface

[rtl/fcrc16_csr.sv]
module fcrc16_csr
   import fcrc16_pkg::*;
   (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [CRC_W-1:0] csr_wdata,
   output cfg_type          cfg
   );

   logic [CRC_W-1:0] gen_ff;
   logic [CRC_W-1:0] init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= GEN_RESET;
         init_ff <= INIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GENERATOR_POLY: gen_ff  <= csr_wdata;
            CSR_INITIAL_VALUE:  init_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.generator_poly = gen_ff;
   assign cfg.initial_value  = init_ff;

endmodule

[rtl/fcrc16_step.sv]
module fcrc16_step
   import fcrc16_pkg::*;
   (
   input  logic [CRC_W-1:0]  crc_cur,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [CRC_W-1:0]  generator_poly,
   output logic [CRC_W-1:0]  crc_next
   );

   logic [IDX_W-1:0] top_idx;
   logic [IDX_W-1:0] shift;

   // highest set generator bit, floor at MIN_TOP_IDX
   always_comb begin
      top_idx = IDX_W'(MIN_TOP_IDX);
      for (int b = MIN_TOP_IDX + 1; b < CRC_W; b++) begin
         if (generator_poly[b]) begin
            top_idx = IDX_W'(b);
         end
      end
   end

   assign shift = top_idx - IDX_W'(MIN_TOP_IDX);

   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_cur ^ ({{(CRC_W-BYTE_W){1'b0}}, data_byte} << shift);
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[top_idx]) begin
            c = (c << 1) ^ generator_poly;
         end else begin
            c = c << 1;
         end
      end
      crc_next = c;
   end

endmodule

[rtl/frame_crc16_generic_poly_unit.sv]
// Frame CRC-16 with a programmable generator, MSB first.
//
// req_bus carries one frame byte per transfer with last_byte marking the
// final byte covered by the CRC. rsp_bus carries one crc_value per frame,
// produced after the byte marked last. csr_we/csr_index/csr_wdata write the
// generator word and the per-frame initial value; write them only while no
// transfer is in flight.
//
// A byte is captured in an input register and folded by eight unrolled
// shift/XOR steps into the running CRC, or for a last byte into the output
// register, where the finished CRC sits once its last byte advances.
// Throughput is one byte per cycle unless a last byte waits on the output
// register; the byte fold from input register to running CRC sets that figure.
//
// Reset loads the generator with 0x1021, the initial value and the running
// CRC with 0xFFFF, and empties both registers. When the receiver stalls,
// non-last bytes keep flowing; a last byte waits in the input register until
// the output register frees, and req_bus.ready stays low while it waits.
module frame_crc16_generic_poly_unit
   import fcrc16_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   fcrc16_req_if.sink        req_bus,
   fcrc16_rsp_if.source      rsp_bus,
   input  logic              csr_we,
   input  csr_index_type     csr_index,
   input  logic [CRC_W-1:0]  csr_wdata
   );

   cfg_type cfg;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_data_ff;
   logic              s1_last_ff;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              out_valid_ff, out_valid_in;
   logic [CRC_W-1:0]  out_crc_ff, out_crc_in;
   logic [CRC_W-1:0]  step_crc;
   logic              out_free;
   logic              s1_advance;
   logic              req_fire;
   logic              frame_done;

   fcrc16_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fcrc16_step u_step (
      .crc_cur        (crc_ff),
      .data_byte      (s1_data_ff),
      .generator_poly (cfg.generator_poly),
      .crc_next       (step_crc)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_advance    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign frame_done    = s1_advance && s1_last_ff;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_advance);
   assign crc_in       = s1_advance ? (s1_last_ff ? cfg.initial_value : step_crc) : crc_ff;
   assign out_valid_in = frame_done || (out_valid_ff && !rsp_bus.ready);
   assign out_crc_in   = frame_done ? step_crc : out_crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= INIT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_bus.data_byte;
         s1_last_ff <= req_bus.last_byte;
      end
      out_crc_ff <= out_crc_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.crc_value = out_crc_ff;

   a_nonlast_never_stalls: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_last_ff |-> s1_advance)
      else $error("non-last byte held in input register");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(frame_done))
      else $error("result appeared without a last byte");

   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> crc_ff == $past(cfg.initial_value))
      else $error("running CRC not reloaded after last byte");

   a_block_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input taken while last byte is blocked");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import fcrc16_pkg::*;

   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 60;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CRC_W-1:0] csr_wdata;

   fcrc16_req_if req_bus ();
   fcrc16_rsp_if rsp_bus ();

   frame_crc16_generic_poly_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_byte_type   byte_backlog[$];
   logic [CRC_W-1:0] crc_expect[$];
   logic [CRC_W-1:0] gen_word;
   logic [CRC_W-1:0] init_word;
   logic [CRC_W-1:0] frame_crc;
   frame_byte_type   next_byte;
   logic [CRC_W-1:0] want_crc;
   int burst_left;
   int gap_left;
   int hold_left;
   int stall_mode;
   int mode_left;
   int items_queued;
   int errors;
   int cycle_count;
   bit hold_request;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [CRC_W-1:0] gen,
                                                   input logic [BYTE_W-1:0] data);
      int top;
      logic [CRC_W-1:0] acc;
      top = MIN_TOP_IDX;
      for (int b = MIN_TOP_IDX; b < CRC_W; b++)
         if (gen[b]) top = b;
      acc = crc ^ ({8'h00, data} << (top - MIN_TOP_IDX));
      for (int i = 0; i < BYTE_W; i++) begin
         if (acc[top]) acc = (acc << 1) ^ gen;
         else acc = acc << 1;
      end
      return acc;
   endfunction

   // driver: bursts with random gaps, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         frame_crc = INIT_RESET;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            frame_crc = fold_byte(frame_crc, gen_word, req_bus.data_byte);
            if (req_bus.last_byte) begin
               crc_expect.push_back(frame_crc);
               frame_crc = init_word;
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (byte_backlog.size() > 0) begin
               next_byte = byte_backlog.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.data_byte <= next_byte.data;
               req_bus.last_byte <= next_byte.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern plus an on-demand long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
         stall_mode = 0;
         mode_left = 0;
      end else begin
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: begin
                  rsp_bus.ready <= 1'b1;
               end
               1: begin
                  rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               end
               2: begin
                  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               end
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (crc_expect.size() == 0) begin
            $display("%0t: unexpected transfer, crc_value actual %h", $time,
                     rsp_bus.crc_value);
            errors++;
         end else begin
            want_crc = crc_expect.pop_front();
            if (rsp_bus.crc_value !== want_crc) begin
               $display("%0t: crc_value mismatch, expected %h actual %h", $time,
                        want_crc, rsp_bus.crc_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic last);
      frame_byte_type fb;
      fb.data = data;
      fb.last = last;
      byte_backlog.push_back(fb);
      items_queued++;
   endtask

   task automatic queue_frame(input int len, input bit closed);
      int kind;
      logic [BYTE_W-1:0] data;
      kind = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
         if (kind == 0) data = 8'h00;
         else if (kind == 1) data = 8'hFF;
         else data = BYTE_W'($urandom_range(0, 255));
         queue_byte(data, closed && (i == len - 1));
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (byte_backlog.size() != 0 || req_bus.valid || crc_expect.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CRC_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_GENERATOR_POLY) gen_word = value;
      else init_word = value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [CRC_W-1:0] gen_pick;
      logic [CRC_W-1:0] init_pick;
      int target;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_GENERATOR_POLY;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      gen_word = GEN_RESET;
      init_word = INIT_RESET;
      hold_request = 1'b0;
      items_queued = 0;
      errors = 0;
      cycle_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: check string, byte extremes, bit extremes
      for (int i = 0; i < 9; i++) queue_byte(BYTE_W'(8'h31 + i), i == 8);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'h5A, 1'b0);
      wait_idle();

      // initial value changed mid-frame: takes effect on the next frame
      write_csr(CSR_INITIAL_VALUE, 16'h0000);
      queue_byte(8'h3C, 1'b1);
      queue_byte(8'h00, 1'b0);
      wait_idle();

      // generator changed mid-frame, small generator clamps to bit 7
      write_csr(CSR_GENERATOR_POLY, 16'h0007);
      queue_byte(8'h34, 1'b1);
      wait_idle();
      write_csr(CSR_GENERATOR_POLY, 16'h0000);
      queue_byte(8'h81, 1'b1);
      wait_idle();
      write_csr(CSR_GENERATOR_POLY, 16'h0080);
      queue_byte(8'hC3, 1'b0);
      queue_byte(8'h7E, 1'b1);
      wait_idle();
      write_csr(CSR_GENERATOR_POLY, 16'hFFFF);
      write_csr(CSR_INITIAL_VALUE, 16'hFFFF);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      wait_idle();
      write_csr(CSR_GENERATOR_POLY, 16'h8005);
      queue_byte(8'h01, 1'b1);
      wait_idle();
      write_csr(CSR_GENERATOR_POLY, 16'h0100);
      write_csr(CSR_INITIAL_VALUE, 16'h1234);
      queue_byte(8'hF0, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0: gen_pick = GEN_RESET;
            1: gen_pick = 16'h8005;
            2: gen_pick = CRC_W'($urandom_range(0, 127));
            3: gen_pick = 16'hFFFF;
            4: gen_pick = 16'h0080;
            default: gen_pick = CRC_W'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 3))
            0: init_pick = 16'h0000;
            1: init_pick = 16'hFFFF;
            default: init_pick = CRC_W'($urandom_range(0, 65535));
         endcase
         write_csr(CSR_GENERATOR_POLY, gen_pick);
         if ($urandom_range(0, 3) != 0) write_csr(CSR_INITIAL_VALUE, init_pick);
         target = items_queued + PHASE_ITEMS;
         if (p == 3) begin
            // hold the receiver while short frames keep coming
            hold_request = 1'b1;
            while (items_queued < target) queue_frame($urandom_range(1, 2), 1'b1);
         end else begin
            while (items_queued < target) begin
               if ($urandom_range(0, 9) == 0) queue_frame($urandom_range(13, 40), 1'b1);
               else queue_frame($urandom_range(1, 8), 1'b1);
            end
         end
         if ($urandom_range(0, 2) == 0) queue_frame($urandom_range(1, 4), 1'b0);
      end

      wait_idle();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
